// ----- rtl/vaed_pkg.sv -----
// shared types, constants and helpers of the voice activity endpoint detector
`default_nettype none

package vaed_pkg;

    // samples carried by one frame item
    localparam int FRAME_SAMPLES = 512;

    localparam int CNT_W    = 20;
    localparam int PRE_W    = 16;
    localparam int THR_W    = 17;
    localparam int PROB_W   = 16;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_SAMPLES);
    localparam logic [PRE_W-1:0] FRAME_PRE = PRE_W'(FRAME_SAMPLES);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_IN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOICED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_KEEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME      = 2'd0,
        OP_LISTEN_ON  = 2'd1,
        OP_LISTEN_OFF = 2'd2,
        OP_RELEASE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_IGNORED      = 3'd0,
        EV_WAITING      = 3'd1,
        EV_STARTED      = 3'd2,
        EV_CONTINUING   = 3'd3,
        EV_DISCARDED    = 3'd4,
        EV_MAX_DONE     = 3'd5,
        EV_SILENCE_DONE = 3'd6,
        EV_CONTROL      = 3'd7
    } event_t;

    typedef struct packed {
        logic [THR_W-1:0] start_threshold;
        logic [THR_W-1:0] end_threshold;
        logic [PRE_W-1:0] lead_in_limit;
        logic [CNT_W-1:0] min_voiced;
        logic [CNT_W-1:0] silence_limit;
        logic [CNT_W-1:0] trailing_keep;
        logic [CNT_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        event_t           ev;
        logic             decision;
        logic [CNT_W-1:0] utt_len;
        logic [CNT_W-1:0] trimmed;
        logic             listening;
        logic             latched;
    } result_t;

    // saturating add of two counts
    function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/voice_activity_endpoint_detector.sv -----
// top level of the voice activity endpoint detector
//
// frame and control items arrive on the in_valid / in_ready channel: op picks
// a frame, listen on, listen off or latch release, speech_probability rides
// with frames. every item gives exactly one result on the out_valid /
// out_ready channel: event code, speech decision, trimmed utterance length,
// samples trimmed, and the listening and latched modes after the item.
// thresholds and sample limits sit in a bank written over the cfg channel
// (cfg_index, cfg_data), which is always ready; write it only while idle.
// an accepted item lands in an input register, is decided by one pass of
// compare and add logic against the capture state, and the result is held
// in an output register. one item per cycle is sustained while out_ready
// stays high, since the capture state updates in the same edge as the
// result register loads, ready for the next item.
// a receiver stall holds the result register; the input register still
// takes one more item, after which in_ready drops until out_ready returns.
// reset empties both registers, loads the default limits, leaves the block
// not listening and latched, and clears all sample counts.
`default_nettype none

module voice_activity_endpoint_detector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [vaed_pkg::OP_W-1:0]          op,
    input  wire logic [vaed_pkg::PROB_W-1:0]        speech_probability,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [2:0]                              event_res,
    output logic                                    speech_decision,
    output logic [vaed_pkg::CNT_W-1:0]              utterance_samples,
    output logic [vaed_pkg::CNT_W-1:0]              silence_cut,
    output logic                                    listening,
    output logic                                    latched,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vaed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vaed_pkg::CFG_DATA_W-1:0]    cfg_data
);

    vaed_pkg::cfg_t    cfg;
    vaed_pkg::result_t res;

    // input register
    logic                          in_vld_reg, in_vld_next;
    logic [vaed_pkg::OP_W-1:0]     op_reg, op_next;
    logic [vaed_pkg::PROB_W-1:0]   prob_reg, prob_next;

    // result register
    logic                          out_vld_reg, out_vld_next;
    vaed_pkg::result_t             res_reg, res_next;

    logic advance;
    logic fire;

    // result register frees up when empty or when its transfer completes
    assign advance  = !out_vld_reg || out_ready;
    assign fire     = advance && in_vld_reg;
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        op_next     = op_reg;
        prob_next   = prob_reg;
        if (in_ready)
        begin
            in_vld_next = in_valid;
            op_next     = op;
            prob_next   = speech_probability;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        if (advance)
        begin
            out_vld_next = in_vld_reg;
        end
        if (fire)
        begin
            res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prob_reg <= prob_next;
        res_reg  <= res_next;
    end

    vaed_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vaed_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (op_reg),
        .prob  (prob_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid         = out_vld_reg;
    assign event_res         = res_reg.ev;
    assign speech_decision   = res_reg.decision;
    assign utterance_samples = res_reg.utt_len;
    assign silence_cut       = res_reg.trimmed;
    assign listening         = res_reg.listening;
    assign latched           = res_reg.latched;

endmodule

`default_nettype wire

// ----- rtl/vaed_cfg.sv -----
// configuration register bank of the endpoint detector
`default_nettype none

module vaed_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vaed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vaed_pkg::CFG_DATA_W-1:0]  cfg_data,
    output vaed_pkg::cfg_t                        cfg
);

    vaed_pkg::cfg_t cfg_reg;
    vaed_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                vaed_pkg::CFG_START_THR:
                    cfg_next.start_threshold = cfg_data[vaed_pkg::THR_W-1:0];
                vaed_pkg::CFG_END_THR:
                    cfg_next.end_threshold = cfg_data[vaed_pkg::THR_W-1:0];
                vaed_pkg::CFG_LEAD_IN:
                    cfg_next.lead_in_limit = cfg_data[vaed_pkg::PRE_W-1:0];
                vaed_pkg::CFG_MIN_VOICED:
                    cfg_next.min_voiced = cfg_data[vaed_pkg::CNT_W-1:0];
                vaed_pkg::CFG_SILENCE_LIM:
                    cfg_next.silence_limit = cfg_data[vaed_pkg::CNT_W-1:0];
                vaed_pkg::CFG_TRAIL_KEEP:
                    cfg_next.trailing_keep = cfg_data[vaed_pkg::CNT_W-1:0];
                vaed_pkg::CFG_MAX_LEN:
                    cfg_next.max_length = cfg_data[vaed_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold <= 17'd39322;
            cfg_reg.end_threshold   <= 17'd22938;
            cfg_reg.lead_in_limit   <= 16'd4800;
            cfg_reg.min_voiced      <= 20'd2560;
            cfg_reg.silence_limit   <= 20'd16000;
            cfg_reg.trailing_keep   <= 20'd2400;
            cfg_reg.max_length      <= 20'd480000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vaed_core.sv -----
// capture state and per-item endpoint decision logic
`default_nettype none

module vaed_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [vaed_pkg::OP_W-1:0]      op,
    input  wire logic [vaed_pkg::PROB_W-1:0]    prob,
    input  wire vaed_pkg::cfg_t                 cfg,
    output vaed_pkg::result_t                   res
);

    localparam int CW = vaed_pkg::CNT_W;
    localparam int PW = vaed_pkg::PRE_W;

    logic          listen_reg, listen_next;
    logic          latch_reg, latch_next;
    logic          speech_reg, speech_next;
    logic [PW-1:0] pre_reg, pre_next;
    logic [CW-1:0] buf_reg, buf_next;
    logic [CW-1:0] voiced_reg, voiced_next;
    logic [CW-1:0] silent_reg, silent_next;

    logic [vaed_pkg::THR_W-1:0] thr;
    logic                       dec;
    logic [PW:0]                pre_sum;
    logic [PW-1:0]              pre_sat;
    logic [CW-1:0]              pre_ext;
    logic [CW-1:0]              buf_inc;
    logic [CW-1:0]              voiced_inc;
    logic [CW-1:0]              silent_inc;
    logic [CW-1:0]              voiced_after;
    logic [CW-1:0]              excess;
    logic [CW-1:0]              trim;
    logic                       max_hit;
    logic                       sil_hit;

    // datapath pieces shared by the control cases
    always_comb
    begin
        thr        = speech_reg ? cfg.end_threshold : cfg.start_threshold;
        dec        = {1'b0, prob} >= thr;
        pre_sum    = {1'b0, pre_reg} + {1'b0, vaed_pkg::FRAME_PRE};
        pre_sat    = pre_sum[PW] ? {PW{1'b1}} : pre_sum[PW-1:0];
        pre_ext    = {{(CW-PW){1'b0}}, pre_reg};
        buf_inc    = vaed_pkg::sat_add_cnt(buf_reg, vaed_pkg::FRAME_CNT);
        voiced_inc = vaed_pkg::sat_add_cnt(voiced_reg, vaed_pkg::FRAME_CNT);
        silent_inc = vaed_pkg::sat_add_cnt(silent_reg, vaed_pkg::FRAME_CNT);
        voiced_after = dec ? voiced_inc : voiced_reg;
        max_hit    = buf_inc >= cfg.max_length;
        sil_hit    = !dec && (silent_inc >= cfg.silence_limit);
        // trailing silence beyond the kept amount, capped at the buffer
        excess     = (silent_inc > cfg.trailing_keep) ? silent_inc - cfg.trailing_keep : '0;
        trim       = (excess > buf_inc) ? buf_inc : excess;
    end

    always_comb
    begin
        listen_next = listen_reg;
        latch_next  = latch_reg;
        speech_next = speech_reg;
        pre_next    = pre_reg;
        buf_next    = buf_reg;
        voiced_next = voiced_reg;
        silent_next = silent_reg;
        res.ev       = vaed_pkg::EV_CONTROL;
        res.decision = 1'b0;
        res.utt_len  = '0;
        res.trimmed  = '0;

        case (vaed_pkg::op_t'(op))
            vaed_pkg::OP_LISTEN_ON:
            begin
                if (!listen_reg)
                begin
                    listen_next = 1'b1;
                    latch_next  = 1'b0;
                    speech_next = 1'b0;
                    pre_next    = '0;
                    buf_next    = '0;
                    voiced_next = '0;
                    silent_next = '0;
                end
            end
            vaed_pkg::OP_LISTEN_OFF:
            begin
                listen_next = 1'b0;
                latch_next  = 1'b1;
                speech_next = 1'b0;
                pre_next    = '0;
                buf_next    = '0;
                voiced_next = '0;
                silent_next = '0;
            end
            vaed_pkg::OP_RELEASE:
            begin
                if (listen_reg)
                    latch_next = 1'b0;
            end
            vaed_pkg::OP_FRAME:
            begin
                if (!listen_reg || latch_reg)
                begin
                    res.ev = vaed_pkg::EV_IGNORED;
                end
                else if (!speech_reg)
                begin
                    res.decision = dec;
                    if (!dec)
                    begin
                        pre_next = (pre_sat > cfg.lead_in_limit) ? cfg.lead_in_limit
                                                                 : pre_sat;
                        res.ev   = vaed_pkg::EV_WAITING;
                    end
                    else
                    begin
                        speech_next = 1'b1;
                        buf_next    = vaed_pkg::sat_add_cnt(pre_ext, vaed_pkg::FRAME_CNT);
                        voiced_next = vaed_pkg::FRAME_CNT;
                        silent_next = '0;
                        res.ev      = vaed_pkg::EV_STARTED;
                    end
                end
                else
                begin
                    res.decision = dec;
                    buf_next     = buf_inc;
                    voiced_next  = voiced_after;
                    silent_next  = dec ? '0 : silent_inc;
                    if (max_hit || sil_hit)
                    begin
                        speech_next = 1'b0;
                        pre_next    = '0;
                        buf_next    = '0;
                        voiced_next = '0;
                        silent_next = '0;
                        if (voiced_after < cfg.min_voiced)
                        begin
                            res.ev = vaed_pkg::EV_DISCARDED;
                        end
                        else if (max_hit)
                        begin
                            latch_next  = 1'b1;
                            res.ev      = vaed_pkg::EV_MAX_DONE;
                            res.utt_len = buf_inc;
                        end
                        else
                        begin
                            latch_next  = 1'b1;
                            res.ev      = vaed_pkg::EV_SILENCE_DONE;
                            res.utt_len = buf_inc - trim;
                            res.trimmed = trim;
                        end
                    end
                    else
                    begin
                        res.ev = vaed_pkg::EV_CONTINUING;
                    end
                end
            end
            default:
            begin
                res.ev = vaed_pkg::EV_CONTROL;
            end
        endcase

        res.listening = listen_next;
        res.latched   = latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg <= 1'b0;
            latch_reg  <= 1'b1;
            speech_reg <= 1'b0;
            pre_reg    <= '0;
            buf_reg    <= '0;
            voiced_reg <= '0;
            silent_reg <= '0;
        end
        else if (fire)
        begin
            listen_reg <= listen_next;
            latch_reg  <= latch_next;
            speech_reg <= speech_next;
            pre_reg    <= pre_next;
            buf_reg    <= buf_next;
            voiced_reg <= voiced_next;
            silent_reg <= silent_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vaed_checker.sv -----
// port-level checks of the endpoint detector and their bind
`default_nettype none

module vaed_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [2:0]                         event_res,
    input  wire logic                               speech_decision,
    input  wire logic [vaed_pkg::CNT_W-1:0]         utterance_samples,
    input  wire logic [vaed_pkg::CNT_W-1:0]         silence_cut,
    input  wire logic                               listening,
    input  wire logic                               latched
);

    // a stalled result stays valid and holds its event code and lengths
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(utterance_samples) && $stable(silence_cut))
        else $error("stalled result changed");

    // lengths only reported on completion events
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != vaed_pkg::EV_MAX_DONE
            && event_res != vaed_pkg::EV_SILENCE_DONE
        |-> utterance_samples == '0 && silence_cut == '0)
        else $error("length outside completion");

    // ignored frames and control items carry no decision
    a_no_dec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == vaed_pkg::EV_IGNORED
            || event_res == vaed_pkg::EV_CONTROL) |-> !speech_decision)
        else $error("decision on non-frame result");

    // an accepted utterance leaves the block latched and listening
    a_done_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == vaed_pkg::EV_MAX_DONE
            || event_res == vaed_pkg::EV_SILENCE_DONE) |-> latched && listening)
        else $error("completion without latch");

    // an active frame event needs listening and no latch
    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == vaed_pkg::EV_STARTED
            || event_res == vaed_pkg::EV_CONTINUING
            || event_res == vaed_pkg::EV_WAITING) |-> listening && !latched)
        else $error("frame processed while latched or off");

endmodule

bind voice_activity_endpoint_detector vaed_checker u_checker (.*);

`default_nettype wire
